// ===== src/button_digit_setter_fsm_macros.svh =====
// Assertion macros used by the digit setter top level.
`ifndef BUTTON_DIGIT_SETTER_FSM_MACROS_SVH
`define BUTTON_DIGIT_SETTER_FSM_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define BDS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bds same-cycle check failed");

// Check that a condition implies a consequence in the next cycle.
`define BDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bds next-cycle check failed");

`endif

// ===== src/bds_pkg.sv =====
// Shared types, register indexes and reset values of the digit setter.
package bds_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 16;

  // Configuration register indexes
  localparam logic [CfgIndexWidth-1:0] REG_TICKS_PER_SECOND = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_BLINK_TICKS      = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_COUNTDOWN_TICKS  = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_HOLD_SECONDS     = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_IDLE_SECONDS     = 3'd4;

  // Reset values of the configuration registers
  localparam logic [15:0] RESET_TICKS_PER_SECOND = 16'd100;
  localparam logic [15:0] RESET_BLINK_TICKS      = 16'd100;
  localparam logic [15:0] RESET_COUNTDOWN_TICKS  = 16'd100;
  localparam logic [3:0]  RESET_HOLD_SECONDS     = 4'd3;
  localparam logic [5:0]  RESET_IDLE_SECONDS     = 6'd10;

  // Reset value of the digit and the display latch
  localparam logic [3:0] RESET_DIGIT = 4'd5;

  typedef struct packed {
    logic [15:0] ticks_per_second;
    logic [15:0] blink_ticks;
    logic [15:0] countdown_ticks;
    logic [3:0]  hold_seconds;
    logic [5:0]  idle_seconds;
  } bds_cfg_t;

  typedef struct packed {
    logic [3:0] shown_digit;
    logic       led_on;
    logic [2:0] mode_now;
  } bds_result_t;

endpackage

// ===== src/button_digit_setter_fsm.sv =====
// Top level of the button digit setter: config registers, step core, result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  in      | input     | in_valid / in_stall  | inc_level, dec_level, clear_level
//  out     | output    | out_valid / out_stall| shown_digit, led_on, mode_now
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item per cycle unless stalled: the step is combinational from the state registers
// into the one-deep result register, so a result appears the cycle after its item.
// in_stall rises only while a result waits in that register and out_stall is high.
// Reset (rst, synchronous) restores the core state, out_valid and the register defaults at once.
// cfg_ready is always high; writes take effect when the core next loads that value.
`include "button_digit_setter_fsm_macros.svh"

module button_digit_setter_fsm (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                inc_level,
  input  logic                                dec_level,
  input  logic                                clear_level,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [3:0]                          shown_digit,
  output logic                                led_on,
  output logic [2:0]                          mode_now,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bds_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [bds_pkg::CfgDataWidth-1:0]    cfg_data
);

  bds_pkg::bds_cfg_t    cfg;
  bds_pkg::bds_result_t result;
  logic                 accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_second <= bds_pkg::RESET_TICKS_PER_SECOND;
      cfg.blink_ticks      <= bds_pkg::RESET_BLINK_TICKS;
      cfg.countdown_ticks  <= bds_pkg::RESET_COUNTDOWN_TICKS;
      cfg.hold_seconds     <= bds_pkg::RESET_HOLD_SECONDS;
      cfg.idle_seconds     <= bds_pkg::RESET_IDLE_SECONDS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bds_pkg::REG_TICKS_PER_SECOND: cfg.ticks_per_second <= cfg_data;
        bds_pkg::REG_BLINK_TICKS:      cfg.blink_ticks      <= cfg_data;
        bds_pkg::REG_COUNTDOWN_TICKS:  cfg.countdown_ticks  <= cfg_data;
        bds_pkg::REG_HOLD_SECONDS:     cfg.hold_seconds     <= cfg_data[3:0];
        bds_pkg::REG_IDLE_SECONDS:     cfg.idle_seconds     <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  bds_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (accept),
    .inc_level   (inc_level),
    .dec_level   (dec_level),
    .clear_level (clear_level),
    .cfg         (cfg),
    .result      (result)
  );

  // Result register valid: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      shown_digit <= result.shown_digit;
      led_on      <= result.led_on;
      mode_now    <= result.mode_now;
    end
  end

  `BDS_ASSERT_NEXT(a_accept_gives_result, accept, out_valid)
  `BDS_ASSERT_NEXT(a_drain_empties, out_valid && !out_stall && !accept, !out_valid)
  `BDS_ASSERT_IMP(a_digit_range, out_valid, shown_digit <= 4'd9)
  `BDS_ASSERT_IMP(a_mode_code, out_valid, mode_now != 3'd7)

endmodule

// ===== src/bds_core.sv =====
// Timer bank and mode state machine: one step per accepted tick item.
module bds_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 inc_level,
  input  logic                 dec_level,
  input  logic                 clear_level,
  input  bds_pkg::bds_cfg_t    cfg,
  output bds_pkg::bds_result_t result
);

  typedef enum logic [2:0] {
    MODE_NORMAL    = 3'd0,
    MODE_INC       = 3'd1,
    MODE_DEC       = 3'd2,
    MODE_CLEAR     = 3'd3,
    MODE_INC_REP   = 3'd4,
    MODE_DEC_REP   = 3'd5,
    MODE_COUNTDOWN = 3'd6
  } mode_t;

  localparam int unsigned T_REPEAT = 0;
  localparam int unsigned T_HOLD   = 1;
  localparam int unsigned T_IDLE   = 2;
  localparam int unsigned T_BLINK  = 3;

  mode_t            mode, mode_next;
  logic [3:0]       digit, digit_next;
  logic [3:0]       countdown_copy, countdown_copy_next;
  logic [3:0]       display_latch, display_latch_next;
  logic             led_level, led_level_next;
  logic [3:0][15:0] timer_count, timer_count_next;
  logic [3:0]       timer_expired, timer_expired_next;
  logic [3:0]       inc_hold_left, inc_hold_left_next;
  logic [3:0]       dec_hold_left, dec_hold_left_next;
  logic [1:0]       hold_reached, hold_reached_next;
  logic [5:0]       idle_left, idle_left_next;
  logic             idle_reached, idle_reached_next;
  logic [1:0]       press_done, press_done_next;

  function automatic logic [3:0] digit_up(input logic [3:0] d);
    return (d >= 4'd9) ? 4'd0 : d + 4'd1;
  endfunction

  function automatic logic [3:0] digit_down(input logic [3:0] d);
    return (d == 4'd0 || d > 4'd9) ? 4'd9 : d - 4'd1;
  endfunction

  // Compute the whole step for the current tick
  always_comb begin
    logic       w;
    logic       lvl;
    logic [3:0] left;
    logic       restart;

    mode_next           = mode;
    digit_next          = digit;
    countdown_copy_next = countdown_copy;
    display_latch_next  = display_latch;
    led_level_next      = led_level;
    inc_hold_left_next  = inc_hold_left;
    dec_hold_left_next  = dec_hold_left;
    hold_reached_next   = hold_reached;
    idle_left_next      = idle_left;
    idle_reached_next   = idle_reached;
    press_done_next     = press_done;
    w                   = 1'b0;
    lvl                 = 1'b0;
    left                = 4'd0;
    restart             = 1'b0;

    // Count all timers down, flag the ones that reach zero
    for (int i = 0; i < 4; i++) begin
      if (timer_count[i] != 16'd0) begin
        timer_count_next[i]   = timer_count[i] - 16'd1;
        timer_expired_next[i] = timer_expired[i] | (timer_count[i] == 16'd1);
      end else begin
        timer_count_next[i]   = 16'd0;
        timer_expired_next[i] = timer_expired[i];
      end
    end

    // Toggle the LED on blink expiry (every mode does this)
    if (timer_expired_next[T_BLINK]) begin
      timer_count_next[T_BLINK]   = cfg.blink_ticks;
      timer_expired_next[T_BLINK] = 1'b0;
      led_level_next              = ~led_level;
    end

    case (mode)
      MODE_INC, MODE_DEC: begin
        w   = (mode == MODE_DEC);
        lvl = w ? dec_level : inc_level;
        if (!press_done[w]) begin
          digit_next         = w ? digit_down(digit) : digit_up(digit);
          display_latch_next = digit_next;
          press_done_next[w] = 1'b1;
        end
        // One-second hold check
        if (timer_expired_next[T_HOLD]) begin
          timer_count_next[T_HOLD]   = cfg.ticks_per_second;
          timer_expired_next[T_HOLD] = 1'b0;
          if (lvl) begin
            left = w ? dec_hold_left : inc_hold_left;
            if (left != 4'd0) left = left - 4'd1;
            if (left == 4'd0) hold_reached_next[w] = 1'b1;
            if (w) dec_hold_left_next = left;
            else inc_hold_left_next = left;
          end
        end
        if (hold_reached_next[w]) mode_next = w ? MODE_DEC_REP : MODE_INC_REP;
        if (!lvl) begin
          mode_next          = MODE_NORMAL;
          press_done_next[w] = 1'b0;
          restart            = 1'b1;
        end
      end
      MODE_CLEAR: begin
        digit_next         = 4'd0;
        display_latch_next = 4'd0;
        if (!clear_level) begin
          mode_next = MODE_NORMAL;
          restart   = 1'b1;
        end
      end
      MODE_INC_REP, MODE_DEC_REP: begin
        w   = (mode == MODE_DEC_REP);
        lvl = w ? dec_level : inc_level;
        if (timer_expired_next[T_REPEAT]) begin
          timer_count_next[T_REPEAT]   = cfg.ticks_per_second;
          timer_expired_next[T_REPEAT] = 1'b0;
          digit_next         = w ? digit_down(digit) : digit_up(digit);
          display_latch_next = digit_next;
        end
        if (!lvl) begin
          mode_next          = MODE_NORMAL;
          press_done_next[w] = 1'b0;
          restart            = 1'b1;
        end
      end
      MODE_COUNTDOWN: begin
        if (timer_expired_next[T_IDLE]) begin
          timer_count_next[T_IDLE]   = cfg.countdown_ticks;
          timer_expired_next[T_IDLE] = 1'b0;
          if (countdown_copy != 4'd0) countdown_copy_next = countdown_copy - 4'd1;
          display_latch_next = countdown_copy_next;
        end
        // Leave on a press: increment steps down, decrement steps up
        if (inc_level) begin
          digit_next = digit_down(digit);
          mode_next  = MODE_NORMAL;
          restart    = 1'b1;
        end else if (dec_level) begin
          digit_next = digit_up(digit);
          mode_next  = MODE_NORMAL;
          restart    = 1'b1;
        end
      end
      default: begin
        mode_next          = MODE_NORMAL;
        inc_hold_left_next = cfg.hold_seconds;
        dec_hold_left_next = cfg.hold_seconds;
        hold_reached_next  = 2'b00;
        display_latch_next = digit;
        // One-second idle check
        if (timer_expired_next[T_IDLE]) begin
          timer_count_next[T_IDLE]   = cfg.ticks_per_second;
          timer_expired_next[T_IDLE] = 1'b0;
          if (idle_left != 6'd0) idle_left_next = idle_left - 6'd1;
          if (idle_left_next == 6'd0) idle_reached_next = 1'b1;
        end
        // Enter countdown with the first step due on the next tick
        if (idle_reached_next) begin
          mode_next                  = MODE_COUNTDOWN;
          timer_expired_next[T_IDLE] = 1'b1;
          countdown_copy_next        = digit;
        end
        if (inc_level || dec_level) begin
          mode_next                    = inc_level ? MODE_INC : MODE_DEC;
          timer_count_next[T_HOLD]     = cfg.ticks_per_second;
          timer_expired_next[T_HOLD]   = 1'b0;
          timer_count_next[T_REPEAT]   = cfg.ticks_per_second;
          timer_expired_next[T_REPEAT] = 1'b0;
        end
        if (clear_level) mode_next = MODE_CLEAR;
      end
    endcase

    // Restart the idle second count on return to normal
    if (restart) begin
      idle_left_next             = cfg.idle_seconds;
      idle_reached_next          = 1'b0;
      timer_count_next[T_IDLE]   = cfg.ticks_per_second;
      timer_expired_next[T_IDLE] = 1'b0;
    end
  end

  // Hold state, advance on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_NORMAL;
      digit          <= bds_pkg::RESET_DIGIT;
      countdown_copy <= 4'd0;
      display_latch  <= bds_pkg::RESET_DIGIT;
      led_level      <= 1'b0;
      timer_count    <= {bds_pkg::RESET_BLINK_TICKS, bds_pkg::RESET_TICKS_PER_SECOND,
                         16'd0, 16'd0};
      timer_expired  <= 4'b0000;
      inc_hold_left  <= bds_pkg::RESET_HOLD_SECONDS;
      dec_hold_left  <= bds_pkg::RESET_HOLD_SECONDS;
      hold_reached   <= 2'b00;
      idle_left      <= bds_pkg::RESET_IDLE_SECONDS;
      idle_reached   <= 1'b0;
      press_done     <= 2'b00;
    end else if (step) begin
      mode           <= mode_next;
      digit          <= digit_next;
      countdown_copy <= countdown_copy_next;
      display_latch  <= display_latch_next;
      led_level      <= led_level_next;
      timer_count    <= timer_count_next;
      timer_expired  <= timer_expired_next;
      inc_hold_left  <= inc_hold_left_next;
      dec_hold_left  <= dec_hold_left_next;
      hold_reached   <= hold_reached_next;
      idle_left      <= idle_left_next;
      idle_reached   <= idle_reached_next;
      press_done     <= press_done_next;
    end
  end

  // Result of this step
  assign result.shown_digit = display_latch_next;
  assign result.led_on      = led_level_next;
  assign result.mode_now    = mode_next;

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the button digit setter: predictor, scoreboard and traffic.
`timescale 1ns / 100ps

module tb;

  localparam int  HALF_PERIOD_NS = 10;
  localparam int  RESET_CYCLES   = 11;
  localparam int  DRAIN_LIMIT    = 2000;
  localparam int  HOLDOFF_CYCLES = 80;
  localparam int  TIMEOUT_NS     = 4_000_000;

  // Timer slots of the predictor
  localparam int TMR_REPEAT = 0;
  localparam int TMR_HOLD   = 1;
  localparam int TMR_IDLE   = 2;
  localparam int TMR_BLINK  = 3;

  // Button levels of one item: {inc, dec, clear}
  localparam logic [2:0] LV_NONE = 3'b000;
  localparam logic [2:0] LV_INC  = 3'b100;
  localparam logic [2:0] LV_DEC  = 3'b010;
  localparam logic [2:0] LV_CLR  = 3'b001;

  typedef enum logic [2:0] {
    MODE_NORMAL    = 3'd0,
    MODE_INC       = 3'd1,
    MODE_DEC       = 3'd2,
    MODE_CLEAR     = 3'd3,
    MODE_INC_REP   = 3'd4,
    MODE_DEC_REP   = 3'd5,
    MODE_COUNTDOWN = 3'd6
  } mode_t;

  // Mirror of the digit setter: tracks its registers and state, queues the readouts due
  class digit_setter_mirror;
    logic [15:0] tps, blink_len, cd_len;
    logic [3:0]  hold_s;
    logic [5:0]  idle_s;

    mode_t       mode;
    logic [3:0]  digit, cd_copy, latch;
    logic        led;
    logic [15:0] tmr_count [4];
    logic        tmr_done [4];
    logic [3:0]  hold_left [2];
    logic        hold_reached [2];
    logic [5:0]  idle_left;
    logic        idle_reached;
    logic        press_done [2];

    bds_pkg::bds_result_t due_readouts [$];
    int                   mismatches;

    function new();
      tps = bds_pkg::RESET_TICKS_PER_SECOND;
      blink_len = bds_pkg::RESET_BLINK_TICKS;
      cd_len = bds_pkg::RESET_COUNTDOWN_TICKS;
      hold_s = bds_pkg::RESET_HOLD_SECONDS;
      idle_s = bds_pkg::RESET_IDLE_SECONDS;
      mode = MODE_NORMAL;
      digit = bds_pkg::RESET_DIGIT;
      cd_copy = 4'd0;
      latch = bds_pkg::RESET_DIGIT;
      led = 1'b0;
      for (int t = 0; t < 4; t++) begin
        tmr_count[t] = 16'd0;
        tmr_done[t] = 1'b0;
      end
      tmr_count[TMR_IDLE] = tps;
      tmr_count[TMR_BLINK] = blink_len;
      for (int w = 0; w < 2; w++) begin
        hold_left[w] = hold_s;
        hold_reached[w] = 1'b0;
        press_done[w] = 1'b0;
      end
      idle_left = idle_s;
      idle_reached = 1'b0;
      mismatches = 0;
    endfunction

    function void set_register(logic [bds_pkg::CfgIndexWidth-1:0] idx,
                               logic [bds_pkg::CfgDataWidth-1:0] data);
      case (idx)
        bds_pkg::REG_TICKS_PER_SECOND: tps = data;
        bds_pkg::REG_BLINK_TICKS:      blink_len = data;
        bds_pkg::REG_COUNTDOWN_TICKS:  cd_len = data;
        bds_pkg::REG_HOLD_SECONDS:     hold_s = data[3:0];
        bds_pkg::REG_IDLE_SECONDS:     idle_s = data[5:0];
        default: ;
      endcase
    endfunction

    function logic [3:0] step_up(logic [3:0] d);
      return (d >= 4'd9) ? 4'd0 : d + 4'd1;
    endfunction

    function logic [3:0] step_down(logic [3:0] d);
      return (d == 4'd0 || d > 4'd9) ? 4'd9 : d - 4'd1;
    endfunction

    function void load_timer(int t, logic [15:0] ticks);
      tmr_count[t] = ticks;
      tmr_done[t] = 1'b0;
    endfunction

    function void toggle_led_if_due();
      if (tmr_done[TMR_BLINK]) begin
        load_timer(TMR_BLINK, blink_len);
        led = ~led;
      end
    endfunction

    // Return to normal mode and restart the idle count; which < 0 leaves press flags alone
    function void to_normal(int which);
      mode = MODE_NORMAL;
      if (which >= 0) press_done[which] = 1'b0;
      idle_left = idle_s;
      idle_reached = 1'b0;
      load_timer(TMR_IDLE, tps);
    endfunction

    // Advance one timer tick and queue the readout it produces
    function void apply_tick(logic inc, logic dec, logic clr);
      bds_pkg::bds_result_t r;
      int                   w;
      logic                 lvl;
      for (int t = 0; t < 4; t++) begin
        if (tmr_count[t] != 16'd0) begin
          tmr_count[t]--;
          if (tmr_count[t] == 16'd0) tmr_done[t] = 1'b1;
        end
      end

      case (mode)
        MODE_INC, MODE_DEC: begin
          w = (mode == MODE_INC) ? 0 : 1;
          lvl = (w == 0) ? inc : dec;
          if (!press_done[w]) begin
            digit = (w == 0) ? step_up(digit) : step_down(digit);
            latch = digit;
            press_done[w] = 1'b1;
          end
          toggle_led_if_due();
          // count held seconds toward auto-repeat
          if (tmr_done[TMR_HOLD]) begin
            load_timer(TMR_HOLD, tps);
            if (lvl) begin
              if (hold_left[w] > 4'd0) hold_left[w]--;
              if (hold_left[w] == 4'd0) hold_reached[w] = 1'b1;
            end
          end
          if (hold_reached[w]) mode = (w == 0) ? MODE_INC_REP : MODE_DEC_REP;
          if (!lvl) to_normal(w);
        end
        MODE_CLEAR: begin
          digit = 4'd0;
          latch = 4'd0;
          toggle_led_if_due();
          if (!clr) to_normal(-1);
        end
        MODE_INC_REP, MODE_DEC_REP: begin
          w = (mode == MODE_INC_REP) ? 0 : 1;
          lvl = (w == 0) ? inc : dec;
          if (tmr_done[TMR_REPEAT]) begin
            load_timer(TMR_REPEAT, tps);
            digit = (w == 0) ? step_up(digit) : step_down(digit);
            latch = digit;
          end
          toggle_led_if_due();
          if (!lvl) to_normal(w);
        end
        MODE_COUNTDOWN: begin
          if (tmr_done[TMR_IDLE]) begin
            load_timer(TMR_IDLE, cd_len);
            if (cd_copy > 4'd0) cd_copy--;
            latch = cd_copy;
          end
          toggle_led_if_due();
          // a press leaves the countdown and nudges the digit the opposite way
          if (inc) begin
            digit = step_down(digit);
            to_normal(-1);
          end else if (dec) begin
            digit = step_up(digit);
            to_normal(-1);
          end
        end
        default: begin
          mode = MODE_NORMAL;
          hold_left[0] = hold_s;
          hold_left[1] = hold_s;
          hold_reached[0] = 1'b0;
          hold_reached[1] = 1'b0;
          latch = digit;
          toggle_led_if_due();
          if (tmr_done[TMR_IDLE]) begin
            load_timer(TMR_IDLE, tps);
            if (idle_left > 6'd0) idle_left--;
            if (idle_left == 6'd0) idle_reached = 1'b1;
          end
          if (idle_reached) begin
            mode = MODE_COUNTDOWN;
            tmr_done[TMR_IDLE] = 1'b1;
            cd_copy = digit;
          end
          // clear beats increment, increment beats decrement
          if (inc || dec) begin
            mode = inc ? MODE_INC : MODE_DEC;
            load_timer(TMR_HOLD, tps);
            load_timer(TMR_REPEAT, tps);
          end
          if (clr) mode = MODE_CLEAR;
        end
      endcase

      r.shown_digit = latch;
      r.led_on = led;
      r.mode_now = mode;
      due_readouts.push_back(r);
    endfunction

    // Compare one readout from the block with the oldest one due
    function void compare_readout(logic [3:0] got_digit, logic got_led, logic [2:0] got_mode);
      bds_pkg::bds_result_t want;
      if (due_readouts.size() == 0) begin
        $error("readout with none due: shown_digit %0d led_on %0d mode_now %0d",
               got_digit, got_led, got_mode);
        mismatches++;
        return;
      end
      want = due_readouts.pop_front();
      if (got_digit !== want.shown_digit) begin
        $error("shown_digit: expected %0d, actual %0d", want.shown_digit, got_digit);
        mismatches++;
      end
      if (got_led !== want.led_on) begin
        $error("led_on: expected %0d, actual %0d", want.led_on, got_led);
        mismatches++;
      end
      if (got_mode !== want.mode_now) begin
        $error("mode_now: expected %0d, actual %0d", want.mode_now, got_mode);
        mismatches++;
      end
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic                              inc_level = 1'b0;
  logic                              dec_level = 1'b0;
  logic                              clear_level = 1'b0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [3:0]                        shown_digit;
  logic                              led_on;
  logic [2:0]                        mode_now;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [bds_pkg::CfgIndexWidth-1:0] cfg_index = '0;
  logic [bds_pkg::CfgDataWidth-1:0]  cfg_data = '0;

  digit_setter_mirror mirror;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holdoff_req = 0;
  int holdoff_seen = 0;
  int holdoff_left = 0;

  button_digit_setter_fsm i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .inc_level   (inc_level),
    .dec_level   (dec_level),
    .clear_level (clear_level),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .shown_digit (shown_digit),
    .led_on      (led_on),
    .mode_now    (mode_now),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #HALF_PERIOD_NS clk = ~clk;

  // Check readouts and drive stall: random idling, or a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) mirror.compare_readout(shown_digit, led_on, mode_now);
      if (holdoff_req != holdoff_seen) begin
        holdoff_seen <= holdoff_req;
        holdoff_left <= HOLDOFF_CYCLES;
        out_stall <= 1'b1;
      end else if (holdoff_left > 0) begin
        holdoff_left <= holdoff_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Offer one item after a random gap; hold it until accepted
  task automatic send_item(logic i, logic d, logic c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    inc_level <= i;
    dec_level <= d;
    clear_level <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    mirror.apply_tick(i, d, c);
    items_sent++;
  endtask

  // Stop offering and wait until every readout due has come or the drain limit runs out
  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (mirror.due_readouts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Write all five registers back to back; the block is idle here
  task automatic write_config(bds_pkg::bds_cfg_t c);
    logic [bds_pkg::CfgIndexWidth-1:0] idx_list [5];
    logic [bds_pkg::CfgDataWidth-1:0]  data_list [5];
    idx_list = '{bds_pkg::REG_TICKS_PER_SECOND, bds_pkg::REG_BLINK_TICKS,
                 bds_pkg::REG_COUNTDOWN_TICKS, bds_pkg::REG_HOLD_SECONDS,
                 bds_pkg::REG_IDLE_SECONDS};
    data_list = '{c.ticks_per_second, c.blink_ticks, c.countdown_ticks,
                  {12'd0, c.hold_seconds}, {10'd0, c.idle_seconds}};
    for (int r = 0; r < 5; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[r];
      cfg_data <= data_list[r];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      mirror.set_register(idx_list[r], data_list[r]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic bds_pkg::bds_cfg_t random_small_cfg();
    bds_pkg::bds_cfg_t c;
    c.ticks_per_second = 16'($urandom_range(4, 1));
    c.blink_ticks = 16'($urandom_range(8, 1));
    c.countdown_ticks = 16'($urandom_range(4, 1));
    c.hold_seconds = 4'($urandom_range(3, 1));
    c.idle_seconds = 6'($urandom_range(3, 1));
    return c;
  endfunction

  // Play button gestures until n more items have been accepted
  task automatic run_gestures(int n);
    int   stop_at, r, len, hold_span, idle_span;
    logic pick_inc;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      hold_span = int'(mirror.hold_s) * int'(mirror.tps) + 2 * int'(mirror.tps) + 2;
      if (hold_span > 40) hold_span = 40;
      idle_span = int'(mirror.idle_s) * int'(mirror.tps) + 4 * int'(mirror.cd_len) + 2;
      if (idle_span > 60) idle_span = 60;
      r = $urandom_range(99);
      pick_inc = 1'($urandom_range(1));
      if (r < 30) begin
        // short tap, then release
        repeat ($urandom_range(3, 1)) send_item(pick_inc, !pick_inc, 1'b0);
        repeat ($urandom_range(3, 1)) send_item(1'b0, 1'b0, 1'b0);
      end else if (r < 55) begin
        // long hold toward auto-repeat, with an occasional stray level
        len = $urandom_range(hold_span, 1);
        repeat (len) begin
          if ($urandom_range(9) == 0)
            send_item(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
          else
            send_item(pick_inc, !pick_inc, 1'b0);
        end
        repeat ($urandom_range(2, 1)) send_item(1'b0, 1'b0, 1'b0);
      end else if (r < 65) begin
        repeat ($urandom_range(3, 1)) send_item(1'b0, 1'b0, 1'b1);
        send_item(1'b0, 1'b0, 1'b0);
      end else if (r < 85) begin
        // stay idle into the countdown, then maybe press out of it
        len = $urandom_range(idle_span, 1);
        repeat (len) send_item(1'b0, 1'b0, 1'b0);
        if ($urandom_range(1)) begin
          send_item(pick_inc, !pick_inc, 1'b0);
          send_item(1'b0, 1'b0, 1'b0);
        end
      end else begin
        repeat ($urandom_range(4, 1))
          send_item(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    logic [2:0] walk [20];
    walk = '{LV_CLR, LV_NONE, LV_NONE, LV_NONE, LV_INC, LV_NONE, LV_NONE, LV_DEC,
             LV_INC, LV_INC, LV_INC, LV_INC, LV_NONE,
             LV_DEC, LV_DEC, LV_DEC, LV_DEC, LV_CLR | LV_INC, LV_INC | LV_DEC, LV_NONE};
    mirror = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Sender idles lightly, receiver heavily
    send_idle_pct = 27;
    recv_idle_pct = 72;

    // reset defaults: every combination of button levels, then random gestures
    for (int k = 0; k < 8; k++) begin
      send_item(k[2], k[1], k[0]);
    end
    run_gestures(60);
    drain();

    // fastest timers: walk countdown, both exits, repeats, clear and joint presses
    write_config('{16'd1, 16'd1, 16'd1, 4'd1, 6'd1});
    for (int k = 0; k < 20; k++) begin
      send_item(walk[k][2], walk[k][1], walk[k][0]);
    end
    run_gestures(150);
    drain();

    // long receiver hold-off fills the block; then a full pause of the sender
    write_config('{16'd2, 16'd3, 16'd1, 4'd1, 6'd2});
    holdoff_req++;
    run_gestures(75);
    drain();
    run_gestures(75);
    drain();

    // Sender idles heavily, receiver lightly
    send_idle_pct = 72;
    recv_idle_pct = 27;
    write_config('{16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15, 6'd63});
    run_gestures(60);
    drain();
    // zero reloads: a timer reloaded with zero never expires again
    write_config('{16'd0, 16'd0, 16'd0, 4'd0, 6'd0});
    run_gestures(40);
    drain();
    write_config('{16'd1, 16'hFFFF, 16'd1, 4'd15, 6'd1});
    run_gestures(120);
    drain();
    write_config(random_small_cfg());
    run_gestures(150);
    drain();

    // No idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_config('{16'd3, 16'd1, 16'd2, 4'd2, 6'd1});
    run_gestures(150);
    drain();
    write_config(random_small_cfg());
    holdoff_req++;
    run_gestures(150);
    drain();

    if (mirror.mismatches == 0 && mirror.due_readouts.size() == 0) begin
      $display("PASS button_digit_setter_fsm");
    end else begin
      if (mirror.due_readouts.size() != 0)
        $error("%0d readouts never arrived", mirror.due_readouts.size());
      $display("FAIL button_digit_setter_fsm");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #(TIMEOUT_NS);
    $display("FAIL button_digit_setter_fsm");
    $finish;
  end

endmodule

// ===== button_digit_setter_fsm.f =====
+incdir+src
src/bds_pkg.sv
src/bds_core.sv
src/button_digit_setter_fsm.sv
bench/tb.sv
